// ----- rtl/core/nslcd_pkg.sv -----
// Shared types, constants and the segment table of the number-string
// to LCD segment-write block. No dependencies.
package nslcd_pkg;

	// Highest glyph address; glyph pairs go down from here.
	localparam logic [3:0] TOP_ADDRESS     = 4'd9;
	localparam logic [3:0] CELSIUS_ADDRESS = 4'd10;
	localparam logic [3:0] PERCENT_ADDRESS = 4'd9;
	// Number of glyphs that fit on the display (1 to 15).
	localparam logic [3:0] DIGIT_COUNT     = 4'd5;
	localparam logic [7:0] DOT_BITS        = 8'h10;

	localparam logic [1:0] MODE_PLAIN   = 2'd0;
	localparam logic [1:0] MODE_CELSIUS = 2'd1;
	localparam logic [1:0] MODE_PERCENT = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [3:0] MINUS_INDEX = 4'd11;

	// Segment patterns: digits 0..9, dot, minus.
	localparam logic [7:0] GLYPH_TABLE [12] = '{
		8'hEB, 8'h60, 8'hC7, 8'hE5, 8'h6C, 8'hAD,
		8'hAF, 8'hE0, 8'hEF, 8'hED, 8'h10, 8'h04
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_HI,
		ST_LO,
		ST_CHK,
		ST_CLR,
		ST_POST
	} state_t;

	typedef enum logic [2:0] {
		EMIT_PRE,
		EMIT_HI,
		EMIT_LO,
		EMIT_CLR,
		EMIT_POST
	} emit_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       emit;
		emit_kind_t kind;
		logic       eor;
		logic       finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic pre;
		logic glyph;
		logic clr;
		logic post;
		logic addr_zero;
	} status_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] pattern;
	} glyph_t;

	// Maps a character to its segment pattern; valid only for digits and minus.
	function automatic glyph_t glyph_lookup(input logic [7:0] ch);
		glyph_t     g;
		logic [7:0] diff;
		diff = ch - CHAR_ZERO;
		g.valid   = 1'b0;
		g.pattern = 8'h00;
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			g.valid   = 1'b1;
			g.pattern = GLYPH_TABLE[diff[3:0]];
		end else if (ch == CHAR_MINUS) begin
			g.valid   = 1'b1;
			g.pattern = GLYPH_TABLE[MINUS_INDEX];
		end
		return g;
	endfunction

endpackage

// ----- rtl/core/number_string_to_lcd_segment_writes_top.sv -----
// Top level of the number-string to LCD segment-write sequencer.
// Depends on nslcd_pkg, nslcd_ctrl and nslcd_dpath.
//
// Usage:
//   The slave stream takes one character per beat, rightmost character first:
//   s_axis_tdata[7:0] is the ASCII code and s_axis_tlast marks the leftmost
//   character. The master stream gives one display memory write per beat:
//   m_axis_tdata[4:0] is the nibble address, [8:5] the nibble, and
//   m_axis_tlast marks the last write caused by one character.
//   The unit mode (plain, Celsius, percent) is written on the cfg channel
//   while the block is idle.
//   Throughput: a character is taken only when the sequencer is idle; it then
//   steps through its write phases one state per cycle while the output register
//   is free, at most one write a cycle and up to 12 writes per character; the next
//   character is taken only after the last one is through.
//   The first write is issued, at the earliest, from the state after acceptance.
//   The single output register sets the pace: when the receiver stalls,
//   the sequencer waits on it and holds the pending write stable.
//   Reset clears the unit mode to plain and returns the string state to its
//   start (next address 9, no dot, no glyph seen); no clearing pass is needed.
module number_string_to_lcd_segment_writes_top (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // leftmost
	// Master stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [4:0] ram_address, [8:5] ram_nibble, rest zero
	output logic        m_axis_tlast,   // end_of_run
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data        // unit_mode
);

	nslcd_pkg::cmd_t    cmd;
	nslcd_pkg::status_t status;
	logic [4:0]         out_address;
	logic [3:0]         out_nibble;

	// The mode register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	nslcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	nslcd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_char     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.cfg_we      (cfg_valid),
		.cfg_mode    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_address (out_address),
		.out_nibble  (out_nibble),
		.out_eor     (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, out_nibble, out_address};

endmodule

// ----- rtl/core/nslcd_ctrl.sv -----
// Controller state machine of the segment-write sequencer.
// Depends on nslcd_pkg; drives nslcd_dpath through cmd_t and reads status_t.
module nslcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nslcd_pkg::status_t  status,
	output nslcd_pkg::cmd_t     cmd
);

	nslcd_pkg::state_t state_q;
	nslcd_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nslcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands. A write is issued only when the output register is free.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.emit   = 1'b0;
		cmd.kind   = nslcd_pkg::EMIT_PRE;
		cmd.eor    = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			nslcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = nslcd_pkg::ST_PRE;
				end
			end
			nslcd_pkg::ST_PRE: begin
				if (!status.pre) begin
					state_d = nslcd_pkg::ST_HI;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = nslcd_pkg::EMIT_PRE;
					cmd.eor  = !(status.glyph || status.clr || status.post);
					state_d  = nslcd_pkg::ST_HI;
				end
			end
			nslcd_pkg::ST_HI: begin
				if (!status.glyph) begin
					state_d = nslcd_pkg::ST_CHK;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = nslcd_pkg::EMIT_HI;
					state_d  = nslcd_pkg::ST_LO;
				end
			end
			nslcd_pkg::ST_LO: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = nslcd_pkg::EMIT_LO;
					cmd.eor  = !(status.clr || status.post);
					state_d  = nslcd_pkg::ST_CHK;
				end
			end
			nslcd_pkg::ST_CHK: begin
				state_d = status.clr ? nslcd_pkg::ST_CLR : nslcd_pkg::ST_POST;
			end
			nslcd_pkg::ST_CLR: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = nslcd_pkg::EMIT_CLR;
					cmd.eor  = status.addr_zero && !status.post;
					if (status.addr_zero) begin
						state_d = nslcd_pkg::ST_POST;
					end
				end
			end
			nslcd_pkg::ST_POST: begin
				if (!status.post) begin
					cmd.finish = 1'b1;
					state_d    = nslcd_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = nslcd_pkg::EMIT_POST;
					cmd.eor    = 1'b1;
					cmd.finish = 1'b1;
					state_d    = nslcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nslcd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/nslcd_dpath.sv -----
// Datapath of the segment-write sequencer: string state, glyph register,
// unit mode register and the output register. Depends on nslcd_pkg.
module nslcd_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_char,
	input  logic               in_last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_mode,
	input  nslcd_pkg::cmd_t    cmd,
	output nslcd_pkg::status_t status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         out_address,
	output logic [3:0]         out_nibble,
	output logic               out_eor
);

	logic [1:0] mode_q;
	logic [3:0] addr_q;
	logic       full_q;
	logic       dot_q;
	logic       start_q;
	logic       seen_q;
	logic [3:0] rhn_q;
	logic       last_q;
	logic       pre_q;
	logic       glyph_pend_q;
	logic [7:0] glyph_q;
	logic       out_valid_q;
	logic [4:0] out_addr_q;
	logic [3:0] out_nib_q;
	logic       out_eor_q;

	nslcd_pkg::glyph_t g_in;
	logic       unit_on;
	logic       addr_low;
	logic [3:0] addr_minus2;
	logic [3:0] addr_pred;
	logic [3:0] used_after;
	logic [7:0] glyph_dot;
	logic [4:0] emit_addr;
	logic [3:0] emit_nib;

	// Decode of the incoming character and the address after the pending glyph.
	always_comb begin
		g_in        = nslcd_pkg::glyph_lookup(in_char);
		unit_on     = (mode_q == nslcd_pkg::MODE_CELSIUS) ||
		              (mode_q == nslcd_pkg::MODE_PERCENT);
		addr_low    = (addr_q < 4'd2);
		addr_minus2 = addr_q - 4'd2;
		used_after  = (nslcd_pkg::TOP_ADDRESS - addr_minus2) >> 1;
		addr_pred   = glyph_pend_q ? (addr_low ? 4'd0 : addr_minus2) : addr_q;
		glyph_dot   = dot_q ? (glyph_q | nslcd_pkg::DOT_BITS) : glyph_q;
	end

	// Status to the controller.
	always_comb begin
		status.out_free  = !out_valid_q || out_ready;
		status.pre       = pre_q;
		status.glyph     = glyph_pend_q;
		status.clr       = last_q && (addr_pred != 4'd0);
		status.post      = last_q && unit_on;
		status.addr_zero = (addr_q == 4'd0);
	end

	// Address and nibble of the write being issued.
	always_comb begin
		emit_addr = 5'd0;
		emit_nib  = 4'd0;
		unique case (cmd.kind)
			nslcd_pkg::EMIT_PRE: begin
				emit_addr = (mode_q == nslcd_pkg::MODE_CELSIUS) ?
				            {1'b0, nslcd_pkg::PERCENT_ADDRESS} :
				            {1'b0, nslcd_pkg::CELSIUS_ADDRESS};
				emit_nib  = 4'h0;
			end
			nslcd_pkg::EMIT_HI: begin
				emit_addr = {1'b0, addr_q};
				emit_nib  = glyph_dot[7:4];
			end
			nslcd_pkg::EMIT_LO: begin
				emit_addr = {1'b0, addr_q - 4'd1};
				emit_nib  = glyph_q[3:0];
			end
			nslcd_pkg::EMIT_CLR: begin
				emit_addr = {1'b0, addr_q};
				emit_nib  = 4'h0;
			end
			nslcd_pkg::EMIT_POST: begin
				emit_addr = (mode_q == nslcd_pkg::MODE_CELSIUS) ?
				            {1'b0, nslcd_pkg::CELSIUS_ADDRESS} :
				            {1'b0, nslcd_pkg::PERCENT_ADDRESS};
				emit_nib  = (mode_q == nslcd_pkg::MODE_CELSIUS) ? 4'hF : (rhn_q | 4'h1);
			end
			default: begin
				emit_addr = 5'd0;
				emit_nib  = 4'h0;
			end
		endcase
	end

	// Unit mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nslcd_pkg::MODE_PLAIN;
		end else if (cfg_we) begin
			mode_q <= cfg_mode;
		end
	end

	// String state and per-character flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= nslcd_pkg::TOP_ADDRESS;
			full_q       <= 1'b0;
			dot_q        <= 1'b0;
			start_q      <= 1'b1;
			seen_q       <= 1'b0;
			rhn_q        <= 4'h0;
			last_q       <= 1'b0;
			pre_q        <= 1'b0;
			glyph_pend_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q       <= in_last;
				pre_q        <= start_q && unit_on;
				start_q      <= 1'b0;
				glyph_pend_q <= !full_q && g_in.valid;
				if (!full_q && in_char == nslcd_pkg::CHAR_DOT) begin
					dot_q <= 1'b1;
				end
			end
			if (cmd.emit && cmd.kind == nslcd_pkg::EMIT_HI) begin
				dot_q <= 1'b0;
				if (!seen_q) begin
					seen_q <= 1'b1;
					rhn_q  <= glyph_q[7:4];
				end
			end
			if (cmd.emit && cmd.kind == nslcd_pkg::EMIT_LO) begin
				glyph_pend_q <= 1'b0;
				if (addr_low) begin
					addr_q <= 4'd0;
					full_q <= 1'b1;
				end else begin
					addr_q <= addr_minus2;
					if (used_after >= nslcd_pkg::DIGIT_COUNT) begin
						full_q <= 1'b1;
					end
				end
			end
			if (cmd.emit && cmd.kind == nslcd_pkg::EMIT_CLR && addr_q != 4'd0) begin
				addr_q <= addr_q - 4'd1;
			end
			// End of string: back to the initial string state.
			if (cmd.finish && last_q) begin
				addr_q       <= nslcd_pkg::TOP_ADDRESS;
				full_q       <= 1'b0;
				dot_q        <= 1'b0;
				start_q      <= 1'b1;
				seen_q       <= 1'b0;
				rhn_q        <= 4'h0;
				last_q       <= 1'b0;
				pre_q        <= 1'b0;
				glyph_pend_q <= 1'b0;
			end
		end
	end

	// Glyph register; the dot is folded in when the high nibble goes out.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q <= g_in.pattern;
		end else if (cmd.emit && cmd.kind == nslcd_pkg::EMIT_HI) begin
			glyph_q <= glyph_dot;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q <= emit_addr;
			out_nib_q  <= emit_nib;
			out_eor_q  <= cmd.eor;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = out_addr_q;
	assign out_nibble  = out_nib_q;
	assign out_eor     = out_eor_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for number_string_to_lcd_segment_writes_top: drives characters
// and unit modes, predicts the display memory writes and checks every write beat.
// Depends on nslcd_pkg and the top-level RTL module.
module testbench;

	// Spare mode code; the block treats it as a plain number.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS  = 280;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 200000;

	// One expected display memory write.
	typedef struct packed {
		logic [4:0] addr;
		logic [3:0] nib;
		logic       last;
	} lcd_write_t;

	// Predicts the writes of each accepted character and checks the write beats.
	class segment_writes;
		lcd_write_t due[$];
		int         errors;
		logic [1:0] mode;
		logic [3:0] addr;
		logic       full;
		logic       dot;
		logic       at_start;
		logic       seen;
		logic [3:0] first_hi;

		function new();
			errors = 0;
			mode   = nslcd_pkg::MODE_PLAIN;
			restart();
		endfunction

		// String state goes back to its start values; the mode is kept.
		function void restart();
			addr     = nslcd_pkg::TOP_ADDRESS;
			full     = 1'b0;
			dot      = 1'b0;
			at_start = 1'b1;
			seen     = 1'b0;
			first_hi = 4'h0;
		endfunction

		function void set_mode(logic [1:0] value);
			mode = value;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void add(logic [4:0] a, logic [3:0] n);
			lcd_write_t w;
			w.addr = a;
			w.nib  = n;
			w.last = 1'b0;
			due.push_back(w);
		endfunction

		// Works out the writes that one accepted character causes.
		function void take_char(logic [7:0] ch, logic leftmost);
			int         glyph_idx;
			int         lower;
			int         a;
			int         count_before;
			logic [7:0] pat;
			count_before = due.size();

			// The other unit's symbol is blanked before the first glyph.
			if (at_start) begin
				if (mode == nslcd_pkg::MODE_CELSIUS)
					add(5'(nslcd_pkg::PERCENT_ADDRESS), 4'h0);
				else if (mode == nslcd_pkg::MODE_PERCENT)
					add(5'(nslcd_pkg::CELSIUS_ADDRESS), 4'h0);
				at_start = 1'b0;
			end

			glyph_idx = -1;
			if (ch >= nslcd_pkg::CHAR_ZERO && ch <= nslcd_pkg::CHAR_NINE)
				glyph_idx = int'(ch - nslcd_pkg::CHAR_ZERO);
			else if (ch == nslcd_pkg::CHAR_MINUS)
				glyph_idx = int'(nslcd_pkg::MINUS_INDEX);

			// Glyph pair writes, with a pending dot merged into this glyph.
			if (!full) begin
				if (ch == nslcd_pkg::CHAR_DOT) begin
					dot = 1'b1;
				end else if (glyph_idx >= 0) begin
					pat   = nslcd_pkg::GLYPH_TABLE[glyph_idx];
					lower = int'(addr) - 2;
					if (!seen) begin
						seen     = 1'b1;
						first_hi = pat[7:4];
					end
					if (dot) begin
						pat = pat | nslcd_pkg::DOT_BITS;
						dot = 1'b0;
					end
					add(5'(addr), pat[7:4]);
					add(5'(addr - 4'd1), pat[3:0]);
					if (lower < 0) begin
						addr = 4'd0;
						full = 1'b1;
					end else begin
						addr = lower[3:0];
						if ((int'(nslcd_pkg::TOP_ADDRESS) - lower) / 2 >=
						    int'(nslcd_pkg::DIGIT_COUNT))
							full = 1'b1;
					end
				end
			end

			// The leftmost character clears what is left and writes the unit symbol.
			if (leftmost) begin
				if (addr != 4'd0)
					for (a = int'(addr); a >= 0; a--)
						add(a[4:0], 4'h0);
				if (mode == nslcd_pkg::MODE_CELSIUS)
					add(5'(nslcd_pkg::CELSIUS_ADDRESS), 4'hF);
				else if (mode == nslcd_pkg::MODE_PERCENT)
					add(5'(nslcd_pkg::PERCENT_ADDRESS), first_hi | 4'h1);
				restart();
			end

			if (due.size() > count_before)
				due[due.size() - 1].last = 1'b1;
		endfunction

		// Compares one write beat with the oldest expected write.
		function void check_write(logic [15:0] data, logic last);
			lcd_write_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected write addr %0d nibble %h", data[4:0], data[8:5]));
				return;
			end
			want = due.pop_front();
			if (data[4:0] != want.addr)
				report($sformatf("address %0d, want %0d", data[4:0], want.addr));
			if (data[8:5] != want.nib)
				report($sformatf("nibble %h at %0d, want %h", data[8:5], want.addr, want.nib));
			if (last != want.last)
				report($sformatf("end of run %0d at %0d, want %0d", last, want.addr, want.last));
			if (data[15:9] != 7'd0)
				report($sformatf("padding bits %h not zero", data[15:9]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = 2'd0;

	segment_writes board;
	int          items_sent = 0;
	int          cycles = 0;
	logic        calm = 1'b0;

	number_string_to_lcd_segment_writes_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// The receiver stalls now and then, except in a calm stretch.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 8);
	end

	// Every write beat is checked against the prediction.
	always @(posedge clk) begin
		if (board != null && m_axis_tvalid && m_axis_tready)
			board.check_write(m_axis_tdata, m_axis_tlast);
	end

	// Cycle counter that ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Sends one character beat; tvalid stays high for a following beat.
	task automatic send_char(input logic [7:0] ch, input logic leftmost);
		while (!calm && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= leftmost;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_char(ch, leftmost);
		items_sent++;
	endtask

	// Waits until every expected write has come and the block has settled.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the unit mode while the block is idle.
	task automatic write_mode(input logic [1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_mode(value);
		cfg_valid <= 1'b0;
	endtask

	// A well-formed number string with random content, mostly digits.
	task automatic send_number(input int len);
		int         i;
		int         pick;
		logic [7:0] ch;
		for (i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				ch = nslcd_pkg::CHAR_ZERO + 8'($urandom_range(9));
			else if (pick < 75)
				ch = nslcd_pkg::CHAR_MINUS;
			else if (pick < 87)
				ch = nslcd_pkg::CHAR_DOT;
			else
				ch = 8'($urandom_range(255));
			send_char(ch, i == len - 1);
		end
	endtask

	// Random bytes with random end marks, closed by a leftmost beat.
	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
		send_char(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		int phase;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain number: seven glyphs with a dot, so the sixth and seventh are dropped.
		write_mode(nslcd_pkg::MODE_PLAIN);
		send_char("9", 1'b0);
		send_char("8", 1'b0);
		send_char(nslcd_pkg::CHAR_DOT, 1'b0);
		send_char("7", 1'b0);
		send_char("6", 1'b0);
		send_char("5", 1'b0);
		send_char("4", 1'b0);
		send_char("3", 1'b1);
		send_char(nslcd_pkg::CHAR_MINUS, 1'b1);
		// Other characters only, and a dot with no glyph to its left.
		send_char("A", 1'b1);
		send_char(nslcd_pkg::CHAR_DOT, 1'b1);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(nslcd_pkg::CHAR_ZERO, 1'b1);

		write_mode(nslcd_pkg::MODE_CELSIUS);
		send_char("5", 1'b0);
		send_char(nslcd_pkg::CHAR_DOT, 1'b1);
		send_char("1", 1'b1);

		// Percent with no glyph, then a normal percent value.
		write_mode(nslcd_pkg::MODE_PERCENT);
		send_char("x", 1'b1);
		send_char("2", 1'b0);
		send_char(nslcd_pkg::CHAR_NINE, 1'b1);

		write_mode(MODE_SPARE);
		send_char("4", 1'b1);

		// Random phases, each under a random unit mode; one calm phase.
		phase = 0;
		while (items_sent < RANDOM_ITEMS - 20) begin
			write_mode(2'($urandom_range(3)));
			calm = (phase == 2);
			repeat (8) begin
				if ($urandom_range(9) == 0)
					send_noise();
				else
					send_number($urandom_range(1, 9));
			end
			calm = 1'b0;
			phase++;
		end

		drain();
		if (board.pending() != 0)
			board.report("writes still due at end");
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/nslcd_pkg.sv
rtl/core/nslcd_ctrl.sv
rtl/core/nslcd_dpath.sv
rtl/core/number_string_to_lcd_segment_writes_top.sv
tb/testbench.sv
